// ===== rtl/png_scanline_unfilter_rgb_assert.svh =====
// Assertion macros used by the checker of the scanline unfilter block.
`ifndef PNG_SCANLINE_UNFILTER_RGB_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_RGB_ASSERT_SVH

// Checked out of reset only.
`define PSU_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PSU_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/psu_pkg.sv =====
package psu_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int STORE_DEPTH = MAX_WIDTH * 4;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  // Byte column; one spare bit so it can step past the end of the line store.
  localparam int COL_W       = STORE_AW + 1;
  localparam int ROW_W       = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W       = 10;
  // Wide enough for a 10-bit register value and for the largest limit.
  localparam int LIM_W       = 14;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_HAS_ALPHA    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } psu_result_t;

  // Clamp a dimension register into 1 .. limit.
  function automatic logic [LIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [LIM_W-1:0] limit);
    logic [LIM_W-1:0] ext;
    ext = LIM_W'(v);
    if (ext == '0) begin
      return LIM_W'(1);
    end else if (ext > limit) begin
      return limit;
    end
    return ext;
  endfunction

  // Paeth predictor: p = a + b - c, pick the neighbour nearest to p,
  // ties broken in the order a, b, c.
  function automatic logic [7:0] paeth_pick(input logic [7:0] a,
                                            input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [10:0] da;
    logic signed [10:0] db;
    logic signed [10:0] dc;
    logic [9:0]         pa;
    logic [9:0]         pb;
    logic [9:0]         pc;
    da = $signed({3'b000, b}) - $signed({3'b000, c});
    db = $signed({3'b000, a}) - $signed({3'b000, c});
    dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
    pa = da[10] ? 10'(-da) : 10'(da);
    pb = db[10] ? 10'(-db) : 10'(db);
    pc = dc[10] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      return a;
    end else if (pb <= pc) begin
      return b;
    end
    return c;
  endfunction

endpackage

// ===== rtl/png_scanline_unfilter_rgb.sv =====
// A finished pixel is registered in out_r, or in skid_r if out_r is stalled.
// Throughput: one byte per cycle while the skid stage is empty; the line store is
// read one column ahead so its data is waiting.
// Reset (rst_n, synchronous, active low) clears all control state and the error
// flag; the line store is not cleared, as a first row never reads it.
module png_scanline_unfilter_rgb import psu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input byte channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  // pixel channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic                 out_row_end,
  output logic                 out_image_end,
  output logic                 out_bad_filter,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             alpha_r;

  // Unfilter state.
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [1:0]       mod3_r;
  logic [1:0]       mod3_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  filt_kind_t       kind_r;
  filt_kind_t       kind_nxt;
  logic             expect_filt_r;
  logic             expect_filt_nxt;
  logic             error_r;
  logic             error_nxt;
  logic [31:0]      left_r;
  logic [31:0]      left_nxt;
  logic [31:0]      upleft_r;
  logic [31:0]      upleft_nxt;

  // Line store holding the previous reconstructed row.
  logic [7:0]          store_mem [STORE_DEPTH];
  logic [7:0]          rd_data_r;
  logic                store_we;
  logic [STORE_AW-1:0] rd_addr;

  // Output register and skid stage.
  psu_result_t out_r;
  logic        out_valid_r;
  psu_result_t skid_r;
  logic        skid_valid_r;

  logic        accept;
  logic        res_push;
  psu_result_t res_data;
  logic        res_pop;

  // Datapath signals.
  logic [1:0]       k;
  logic [7:0]       nb_a;
  logic [7:0]       nb_b;
  logic [7:0]       nb_c;
  logic [7:0]       sample;
  logic [8:0]       avg_sum;
  logic             in_store;
  logic             last_chan;
  logic [COL_W-1:0] col_inc;
  logic [COL_W-1:0] eff_width;
  logic [LIM_W-1:0] eff_height;
  logic [COL_W-1:0] stride;
  logic             row_done;
  logic             image_done;

  // The skid stage being full is the only reason to hold off the source, so a
  // stalled result never blocks the byte that follows it.
  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign res_pop   = out_valid_r && !out_stall;

  // Effective geometry. Three bytes per pixel without alpha, four with it.
  assign eff_width  = COL_W'(clamp_dim(width_r, LIM_W'(MAX_WIDTH)));
  assign eff_height = clamp_dim(height_r, LIM_W'(MAX_HEIGHT));
  assign stride     = alpha_r ? (eff_width << 2) : ((eff_width << 1) + eff_width);

  // Channel of the current byte: column modulo 3 is tracked in its own
  // counter, column modulo 4 is simply the two low bits.
  assign k         = alpha_r ? col_r[1:0] : mod3_r;
  assign last_chan = alpha_r ? (k == 2'd3) : (k == 2'd2);
  assign in_store  = col_r < COL_W'(STORE_DEPTH);

  assign nb_a = left_r[{k, 3'b000} +: 8];
  assign nb_c = upleft_r[{k, 3'b000} +: 8];
  // Above neighbour: zero on the first row of an image and past the store.
  assign nb_b = (row_r != '0 && in_store) ? rd_data_r : 8'h00;

  assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

  always_comb begin
    case (kind_r)
      FILT_SUB:   sample = in_data_byte + nb_a;
      FILT_UP:    sample = in_data_byte + nb_b;
      FILT_AVG:   sample = in_data_byte + avg_sum[8:1];
      FILT_PAETH: sample = in_data_byte + paeth_pick(nb_a, nb_b, nb_c);
      default:    sample = in_data_byte;
    endcase
  end

  assign col_inc    = col_r + COL_W'(1);
  assign row_done   = last_chan && (col_inc >= stride);
  assign image_done = row_done && ((LIM_W'(row_r) + LIM_W'(1)) >= eff_height);

  // Next state of the unfilter for one accepted byte. Once a bad filter
  // byte has been seen every further byte is swallowed without a result.
  always_comb begin
    col_nxt         = col_r;
    mod3_nxt        = mod3_r;
    row_nxt         = row_r;
    kind_nxt        = kind_r;
    expect_filt_nxt = expect_filt_r;
    error_nxt       = error_r;
    left_nxt        = left_r;
    upleft_nxt      = upleft_r;
    store_we        = 1'b0;
    res_push        = 1'b0;
    res_data        = '0;

    if (accept && !error_r) begin
      if (expect_filt_r) begin
        if (in_data_byte > 8'(FILT_PAETH)) begin
          error_nxt           = 1'b1;
          res_push            = 1'b1;
          res_data.bad_filter = 1'b1;
        end else begin
          kind_nxt        = filt_kind_t'(in_data_byte[2:0]);
          expect_filt_nxt = 1'b0;
          col_nxt         = '0;
          mod3_nxt        = 2'd0;
          left_nxt        = '0;
          upleft_nxt      = '0;
        end
      end else begin
        store_we                          = in_store;
        left_nxt[{k, 3'b000} +: 8]        = sample;
        upleft_nxt[{k, 3'b000} +: 8]      = nb_b;
        col_nxt                           = col_inc;
        mod3_nxt                          = (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;

        if (last_chan) begin
          // Red and green were stored when their bytes went by; blue is
          // either this very byte or was stored ahead of the alpha byte.
          res_push        = 1'b1;
          res_data.red    = left_r[7:0];
          res_data.green  = left_r[15:8];
          res_data.blue   = (k == 2'd2) ? sample : left_r[23:16];
          if (row_done) begin
            res_data.row_end = 1'b1;
            expect_filt_nxt  = 1'b1;
            col_nxt          = '0;
            mod3_nxt         = 2'd0;
            if (image_done) begin
              res_data.image_end = 1'b1;
              row_nxt            = '0;
            end else begin
              row_nxt = row_r + ROW_W'(1);
            end
          end
        end
      end
    end
  end

  // The store is read at the column the next byte will use, so the data sits
  // in rd_data_r by the time that byte arrives. A write always goes to the
  // current column, which differs from the prefetch address whenever both
  // happen in the same cycle.
  assign rd_addr = col_nxt[STORE_AW-1:0];

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[col_r[STORE_AW-1:0]] <= sample;
    end
    rd_data_r <= store_mem[rd_addr];
  end

  // Configuration registers and unfilter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= DIM_W'(1);
      height_r      <= DIM_W'(1);
      alpha_r       <= 1'b0;
      col_r         <= '0;
      mod3_r        <= 2'd0;
      row_r         <= '0;
      kind_r        <= FILT_NONE;
      expect_filt_r <= 1'b1;
      error_r       <= 1'b0;
      left_r        <= '0;
      upleft_r      <= '0;
    end else begin
      col_r         <= col_nxt;
      mod3_r        <= mod3_nxt;
      row_r         <= row_nxt;
      kind_r        <= kind_nxt;
      expect_filt_r <= expect_filt_nxt;
      error_r       <= error_nxt;
      left_r        <= left_nxt;
      upleft_r      <= upleft_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
          CFG_IMAGE_HEIGHT: height_r <= cfg_data;
          CFG_HAS_ALPHA:    alpha_r  <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Output register with a one-entry skid stage behind it. When the skid
  // stage holds a beat the source is stalled, so nothing new arrives then.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (res_pop) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (res_push) begin
      if (!out_valid_r || res_pop) begin
        out_r       <= res_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res_data;
        skid_valid_r <= 1'b1;
      end
    end else if (res_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_r.red;
  assign out_green      = out_r.green;
  assign out_blue       = out_r.blue;
  assign out_row_end    = out_r.row_end;
  assign out_image_end  = out_r.image_end;
  assign out_bad_filter = out_r.bad_filter;

endmodule

// ===== rtl/psu_checker.sv =====
`include "png_scanline_unfilter_rgb_assert.svh"

module psu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_row_end,
  input logic       out_image_end,
  input logic       out_bad_filter
);

  `PSU_CHECK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_bad_filter), "stalled pixel beat changed")
  `PSU_CHECK(a_bad_zero, out_valid && out_bad_filter |-> out_red == 8'h00 && out_green == 8'h00 && out_blue == 8'h00 && !out_row_end && !out_image_end, "error beat carries pixel data")
  `PSU_CHECK(a_img_row, out_valid && out_image_end |-> out_row_end, "image end without row end")
  `PSU_CHECK(a_err_last, out_valid && out_bad_filter && !out_stall |=> !out_valid, "pixel beat after an error beat")
  `PSU_CHECK_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "pixel beat straight after reset")

endmodule

bind png_scanline_unfilter_rgb psu_checker u_psu_checker (.*);
